@@ hw/rtl/rgb_upscale_2x_quad_average_assert.svh @@
// Assertion macros for the upscaler RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef RGB_UPSCALE_2X_QUAD_AVERAGE_ASSERT_SVH
`define RGB_UPSCALE_2X_QUAD_AVERAGE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define RGBUP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger
`define RGBUP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rgbup_pkg.sv @@
// Shared types, constants and the quad-average function of the 2x upscaler.
// Depends on nothing; used by every other RTL file but the assertion header.
`default_nettype none

package rgbup_pkg;

	localparam int PIX_W          = 8;
	localparam int SUM_W          = PIX_W + 2;
	localparam int WIDTH_CFG_W    = 12;
	localparam int HEIGHT_CFG_W   = 13;
	localparam int OUT_ROW_W      = 13;
	localparam int OUT_COL_W      = 12;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int QUEUE_DEPTH    = 2;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Which block of an entry the back end is emitting
	typedef enum logic {
		PH_INTERIOR = 1'b0,
		PH_BORDER   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	// One source column of the three-row window
	typedef struct packed {
		rgb_t top;
		rgb_t mid;
		rgb_t bot;
	} wcol_t;

	// Line store word: two rows back and one row back
	typedef struct packed {
		rgb_t older;
		rgb_t recent;
	} line_t;

	typedef struct packed {
		logic [WIDTH_CFG_W-1:0]  width;
		logic [HEIGHT_CFG_W-1:0] height;
		logic                    restart;
	} cfg_t;

	// Work for the back end caused by one source pixel
	typedef struct packed {
		logic                 int_v;
		logic                 bord_v;
		logic [OUT_ROW_W-1:0] int_row;
		logic [OUT_COL_W-1:0] int_col;
		rgb_t [3:0]           int_pix;
		logic [OUT_ROW_W-1:0] bord_row;
		logic [OUT_COL_W-1:0] bord_col;
		rgb_t                 bord_pix;
	} job_t;

	// Per-channel truncated average of four pixels
	function automatic rgb_t avg4(input rgb_t a, input rgb_t b, input rgb_t c, input rgb_t d);
		logic [SUM_W-1:0] sr;
		logic [SUM_W-1:0] sg;
		logic [SUM_W-1:0] sb;
		rgb_t             res;
		sr = SUM_W'(a.red) + SUM_W'(b.red) + SUM_W'(c.red) + SUM_W'(d.red);
		sg = SUM_W'(a.green) + SUM_W'(b.green) + SUM_W'(c.green) + SUM_W'(d.green);
		sb = SUM_W'(a.blue) + SUM_W'(b.blue) + SUM_W'(c.blue) + SUM_W'(d.blue);
		res.red   = sr[SUM_W-1:2];
		res.green = sg[SUM_W-1:2];
		res.blue  = sb[SUM_W-1:2];
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rgbup_if.sv @@
// Valid/ready channel interfaces for source pixels and output pixels.
// Depends on rgbup_pkg for field widths.
`default_nettype none

interface rgbup_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rgbup_pkg::PIX_W-1:0] red;
	logic [rgbup_pkg::PIX_W-1:0] green;
	logic [rgbup_pkg::PIX_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbup_res_if;
	logic                            valid;
	logic                            ready;
	logic [rgbup_pkg::OUT_ROW_W-1:0] out_row;
	logic [rgbup_pkg::OUT_COL_W-1:0] out_col;
	logic [rgbup_pkg::PIX_W-1:0]     out_red;
	logic [rgbup_pkg::PIX_W-1:0]     out_green;
	logic [rgbup_pkg::PIX_W-1:0]     out_blue;
	logic                            last;

	modport source (output valid, output out_row, output out_col, output out_red,
		output out_green, output out_blue, output last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_red,
		input out_green, input out_blue, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_upscale_2x_quad_average.sv @@
// Channel        | Dir | Handshake   | Payload
// pixel          | in  | valid/ready | red, green, blue
// result         | out | valid/ready | out_row, out_col, out_red, out_green, out_blue, last
// APB config     | in  | psel/penable| image_width at 0x0, image_height at 0x4
//
// Each source pixel yields 0, 4 or 8 output pixels, one per cycle on the result
// port while it is not stalled; the single result port limits the sustained input rate.
// With an idle back end the first result passes the stage-1, queue and output registers.
// A two-entry job queue lets input be taken while the result port is stalled.
// Reset clears counters and handshake state and resets geometry; line store needs no clearing pass.
//
// Top level of the 2x upscaler: APB registers, front end, job queue, back end.
// Depends on rgbup_pkg, rgbup_if, rgbup_front, rgbup_fifo and rgbup_back.
`default_nettype none

module rgb_upscale_2x_quad_average #(
	parameter int MAX_WIDTH  = rgbup_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbup_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [rgbup_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [rgbup_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rgbup_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                  pready,
	rgbup_pix_if.sink                             pixel,
	rgbup_res_if.source                           result
);

	localparam int W_RST = (rgbup_pkg::WIDTH_RESET < MAX_WIDTH)
		? rgbup_pkg::WIDTH_RESET : MAX_WIDTH;
	localparam int H_RST = (rgbup_pkg::HEIGHT_RESET < MAX_HEIGHT)
		? rgbup_pkg::HEIGHT_RESET : MAX_HEIGHT;

	logic [rgbup_pkg::WIDTH_CFG_W-1:0]  width_q;
	logic [rgbup_pkg::HEIGHT_CFG_W-1:0] height_q;
	logic                               cfg_wr;
	rgbup_pkg::reg_idx_t                reg_idx;
	logic [rgbup_pkg::WIDTH_CFG_W-1:0]  wr_width;
	logic [rgbup_pkg::HEIGHT_CFG_W-1:0] wr_height;
	rgbup_pkg::cfg_t                    cfg;
	rgbup_pkg::job_t                    push_job;
	rgbup_pkg::job_t                    head_job;
	logic                               q_push;
	logic                               q_full;
	logic                               q_pop;
	logic                               q_head_valid;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = rgbup_pkg::reg_idx_t'(paddr[2]);

	// Clamp written geometry to 1..max
	always_comb begin
		wr_width  = pwdata[rgbup_pkg::WIDTH_CFG_W-1:0];
		wr_height = pwdata[rgbup_pkg::HEIGHT_CFG_W-1:0];
		if (wr_width == '0) begin
			wr_width = rgbup_pkg::WIDTH_CFG_W'(1);
		end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
			wr_width = rgbup_pkg::WIDTH_CFG_W'(MAX_WIDTH);
		end
		if (wr_height == '0) begin
			wr_height = rgbup_pkg::HEIGHT_CFG_W'(1);
		end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
			wr_height = rgbup_pkg::HEIGHT_CFG_W'(MAX_HEIGHT);
		end
	end

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rgbup_pkg::WIDTH_CFG_W'(W_RST);
			height_q <= rgbup_pkg::HEIGHT_CFG_W'(H_RST);
		end else if (cfg_wr) begin
			case (reg_idx)
				rgbup_pkg::REG_IMAGE_WIDTH:  width_q  <= wr_width;
				rgbup_pkg::REG_IMAGE_HEIGHT: height_q <= wr_height;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			rgbup_pkg::REG_IMAGE_WIDTH:  prdata = rgbup_pkg::APB_DATA_W'(width_q);
			rgbup_pkg::REG_IMAGE_HEIGHT: prdata = rgbup_pkg::APB_DATA_W'(height_q);
			default:                     prdata = '0;
		endcase
	end

	// Any geometry write restarts the frame
	assign cfg = '{width: width_q, height: height_q, restart: cfg_wr};

	rgbup_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pixel  (pixel),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	rgbup_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head_job),
		.head_valid (q_head_valid)
	);

	rgbup_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.result     (result)
	);

endmodule

`default_nettype wire

@@ hw/rtl/rgbup_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on rgbup_pkg for job_t and the queue depth.
`default_nettype none

module rgbup_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rgbup_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output rgbup_pkg::job_t      head,
	output logic                 head_valid
);

	localparam int DEPTH = rgbup_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rgbup_pkg::job_t  entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rgbup_front.sv @@
// Front end: accepts source pixels, keeps the line store and the 3x3 window,
// classifies each pixel into interior and border blocks and builds a job.
// Depends on rgbup_pkg and rgbup_pix_if.
`default_nettype none

module rgbup_front #(
	parameter int MAX_WIDTH  = rgbup_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbup_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rgbup_pkg::cfg_t cfg,
	rgbup_pix_if.sink           pixel,
	input  wire logic           q_full,
	output logic                q_push,
	output rgbup_pkg::job_t     q_job
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CX_W  = ((COL_W > rgbup_pkg::WIDTH_CFG_W) ? COL_W : rgbup_pkg::WIDTH_CFG_W) + 1;
	localparam int RX_W  = ((ROW_W > rgbup_pkg::HEIGHT_CFG_W) ? ROW_W : rgbup_pkg::HEIGHT_CFG_W) + 1;

	rgbup_pkg::line_t line_mem [MAX_WIDTH];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	rgbup_pkg::rgb_t  pix_s1;
	rgbup_pkg::line_t line_s1;
	rgbup_pkg::wcol_t left_q;
	rgbup_pkg::wcol_t mid_q;

	logic             accept;
	logic             fire_s1;
	logic             col_wrap;
	logic             row_wrap;
	logic             interior;
	logic             border;
	rgbup_pkg::wcol_t cur_col;

	assign accept       = pixel.valid && pixel.ready;
	assign fire_s1      = v_s1 && !q_full;
	assign pixel.ready  = !v_s1 || fire_s1;

	// Wrap detection for the position counters
	assign col_wrap = (CX_W'(col_q) + CX_W'(1)) >= CX_W'(cfg.width);
	assign row_wrap = (RX_W'(row_q) + RX_W'(1)) >= RX_W'(cfg.height);

	// Hold the position of the next source pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Capture the pixel and read its column of the line store
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_q;
			row_s1       <= row_q;
			pix_s1.red   <= pixel.red;
			pix_s1.green <= pixel.green;
			pix_s1.blue  <= pixel.blue;
			line_s1      <= line_mem[col_q];
		end
	end

	// Shift the line store down one row at this column.
	// Consecutive pixels hit the same entry only at width one, where no
	// interior block ever reads it.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			line_mem[col_s1] <= '{older: line_s1.recent, recent: pix_s1};
		end
	end

	assign cur_col = '{top: line_s1.older, mid: line_s1.recent, bot: pix_s1};

	// Advance the window by one column
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			left_q <= mid_q;
			mid_q  <= cur_col;
		end
	end

	// Classify the pixel
	assign interior = (RX_W'(row_s1) >= RX_W'(2)) && (CX_W'(col_s1) >= CX_W'(2));
	assign border   = (row_s1 == '0) || (col_s1 == '0)
		|| ((RX_W'(row_s1) + RX_W'(1)) >= RX_W'(cfg.height))
		|| ((CX_W'(col_s1) + CX_W'(1)) >= CX_W'(cfg.width));

	// Build the job: interior block centered one row up and one column left
	always_comb begin
		q_job.int_v      = interior;
		q_job.bord_v     = border;
		q_job.int_row    = rgbup_pkg::OUT_ROW_W'({row_s1 - ROW_W'(1), 1'b0});
		q_job.int_col    = rgbup_pkg::OUT_COL_W'({col_s1 - COL_W'(1), 1'b0});
		q_job.int_pix[0] = rgbup_pkg::avg4(mid_q.mid, mid_q.top, left_q.mid, left_q.top);
		q_job.int_pix[1] = rgbup_pkg::avg4(mid_q.mid, cur_col.mid, mid_q.top, cur_col.top);
		q_job.int_pix[2] = rgbup_pkg::avg4(mid_q.mid, mid_q.bot, left_q.mid, left_q.bot);
		q_job.int_pix[3] = rgbup_pkg::avg4(mid_q.mid, mid_q.bot, cur_col.mid, cur_col.bot);
		q_job.bord_row   = rgbup_pkg::OUT_ROW_W'({row_s1, 1'b0});
		q_job.bord_col   = rgbup_pkg::OUT_COL_W'({col_s1, 1'b0});
		q_job.bord_pix   = pix_s1;
	end

	// Drop pixels that complete no block
	assign q_push = fire_s1 && (interior || border);

endmodule

`default_nettype wire

@@ hw/rtl/rgbup_back.sv @@
// Back end: walks each queued job quadrant by quadrant and drives the
// registered result channel.
// Depends on rgbup_pkg, rgbup_res_if and the assertion macro header.
`default_nettype none
`include "rgb_upscale_2x_quad_average_assert.svh"

module rgbup_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rgbup_pkg::job_t head,
	input  wire logic            head_valid,
	output logic                 pop,
	rgbup_res_if.source          result
);

	rgbup_pkg::phase_t phase_q;
	logic [1:0]        quad_q;
	logic              out_v_q;

	rgbup_pkg::phase_t                 eff_phase;
	logic                              load;
	logic                              final_step;
	logic [rgbup_pkg::OUT_ROW_W-1:0]   row_nxt;
	logic [rgbup_pkg::OUT_COL_W-1:0]   col_nxt;
	rgbup_pkg::rgb_t                   pix_nxt;

	// Border-only jobs start in the border phase
	assign eff_phase  = head.int_v ? phase_q : rgbup_pkg::PH_BORDER;
	assign load       = head_valid && (!out_v_q || result.ready);
	assign final_step = (quad_q == 2'd3)
		&& ((eff_phase == rgbup_pkg::PH_BORDER) || !head.bord_v);
	assign pop        = load && final_step;

	// Select the pixel of the current quadrant
	always_comb begin
		if (eff_phase == rgbup_pkg::PH_INTERIOR) begin
			row_nxt = {head.int_row[rgbup_pkg::OUT_ROW_W-1:1], quad_q[1]};
			col_nxt = {head.int_col[rgbup_pkg::OUT_COL_W-1:1], quad_q[0]};
			pix_nxt = head.int_pix[quad_q];
		end else begin
			row_nxt = {head.bord_row[rgbup_pkg::OUT_ROW_W-1:1], quad_q[1]};
			col_nxt = {head.bord_col[rgbup_pkg::OUT_COL_W-1:1], quad_q[0]};
			pix_nxt = head.bord_pix;
		end
	end

	// Step through quadrants and phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rgbup_pkg::PH_INTERIOR;
			quad_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				if (final_step) begin
					phase_q <= rgbup_pkg::PH_INTERIOR;
					quad_q  <= '0;
				end else if (quad_q == 2'd3) begin
					phase_q <= rgbup_pkg::PH_BORDER;
					quad_q  <= '0;
				end else begin
					quad_q <= quad_q + 2'd1;
				end
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			result.out_row   <= row_nxt;
			result.out_col   <= col_nxt;
			result.out_red   <= pix_nxt.red;
			result.out_green <= pix_nxt.green;
			result.out_blue  <= pix_nxt.blue;
			result.last      <= final_step;
		end
	end

	assign result.valid = out_v_q;

	`RGBUP_ASSERT_IMPLIES(a_pop_has_head, clk, arst_n, pop, head_valid, "pop from empty queue")
	`RGBUP_ASSERT_IMPLIES(a_border_phase_has_block, clk, arst_n, head_valid && (phase_q == rgbup_pkg::PH_BORDER), head.bord_v, "border phase on job without border block")
	`RGBUP_ASSERT_NEXT(a_job_held_until_done, clk, arst_n, load && !final_step, head_valid, "job left queue before its final result")
	`RGBUP_ASSERT_NEXT(a_last_on_final, clk, arst_n, load && final_step, result.valid && result.last, "final result not marked last")

endmodule

`default_nettype wire

@@ sim/tb_rgb_upscale_2x_quad_average.sv @@
// Testbench for the 2x RGB upscaler: a directed table, then random frames of random
// geometry, each output pixel checked against a local prediction of the block.
// Depends on rgbup_pkg, rgbup_if and rgb_upscale_2x_quad_average from the RTL.
`default_nettype none

module tb_rgb_upscale_2x_quad_average;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbup_pkg::*;

	localparam int LINE_MAX      = MAX_WIDTH_DEF;
	localparam int ROWS_MAX      = MAX_HEIGHT_DEF;
	localparam int DIRECTED_LEN  = 33;
	localparam int RANDOM_PIXELS = 300;
	localparam int CALM_PIXELS   = 50;
	localparam int PHASE_CAP     = 120;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 2000;

	// One output pixel as the result channel carries it
	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		rgb_t                 pix;
		logic                 last;
	} out_pix_t;

	typedef enum logic {
		STIM_PIXEL  = 1'b0,
		STIM_CONFIG = 1'b1
	} stim_kind_t;

	// Directed table row: a pixel, or a register write between phases
	typedef struct {
		stim_kind_t           kind;
		reg_idx_t             idx;
		logic [APB_DATA_W-1:0] value;
		rgb_t                 pix;
		bit                   typed;
		logic [OUT_ROW_W-1:0] exp_row;
		logic [OUT_COL_W-1:0] exp_col;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rgbup_pix_if pix_ch ();
	rgbup_res_if res_ch ();

	rgb_upscale_2x_quad_average DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pix_ch),
		.result  (res_ch)
	);

	// Prediction state: geometry, frame position, line stores and window
	int unsigned frame_width;
	int unsigned frame_height;
	int unsigned cur_row;
	int unsigned cur_col;
	rgb_t        older_line [LINE_MAX];
	rgb_t        recent_line [LINE_MAX];
	rgb_t        left_col [3];
	rgb_t        mid_col [3];
	out_pix_t    upscaled_queue [$];

	stim_row_t   directed_rows [DIRECTED_LEN];
	int          error_count;
	int          table_errors;
	int          pixels_sent;
	int          results_checked;
	int          averaged_results;
	int          settings_used;
	int          quiet_cycles;
	bit          calm;
	bit          hold_req;
	bit          hold_done;
	bit          hold_active;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned limit);
		if (v == 0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// Per-channel sum of four pixels, truncated by two bits
	function automatic rgb_t mean4(rgb_t a, rgb_t b, rgb_t c, rgb_t d);
		rgb_t res;
		int   sum;
		for (int k = 0; k < 3; k++) begin
			sum = a[8*k +: 8] + b[8*k +: 8] + c[8*k +: 8] + d[8*k +: 8];
			res[8*k +: 8] = sum[9:2];
		end
		return res;
	endfunction

	// A register write restarts the frame
	function automatic void set_geometry(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		if (idx == REG_IMAGE_WIDTH)
			frame_width = clamp_size(32'(value[WIDTH_CFG_W-1:0]), LINE_MAX);
		else
			frame_height = clamp_size(32'(value[HEIGHT_CFG_W-1:0]), ROWS_MAX);
		cur_row = 0;
		cur_col = 0;
	endfunction

	// Queue the output pixels one source pixel causes; return their count
	function automatic int upscale_pixel(rgb_t p, output out_pix_t head);
		out_pix_t             blk [8];
		rgb_t                 quad [4];
		rgb_t                 col_now [3];
		int                   n;
		logic [OUT_ROW_W-1:0] orow;
		logic [OUT_COL_W-1:0] ocol;
		n = 0;
		col_now[0] = older_line[cur_col];
		col_now[1] = recent_line[cur_col];
		col_now[2] = p;

		// interior block of the pixel up-left, once its lower-right neighbor is here
		if (cur_row >= 2 && cur_col >= 2) begin
			quad[0] = mean4(mid_col[1], mid_col[0], left_col[1], left_col[0]);
			quad[1] = mean4(mid_col[1], col_now[1], mid_col[0], col_now[0]);
			quad[2] = mean4(mid_col[1], mid_col[2], left_col[1], left_col[2]);
			quad[3] = mean4(mid_col[1], mid_col[2], col_now[1], col_now[2]);
			orow = OUT_ROW_W'(2 * (cur_row - 1));
			ocol = OUT_COL_W'(2 * (cur_col - 1));
			for (int q = 0; q < 4; q++) begin
				blk[n].row  = orow + OUT_ROW_W'(q / 2);
				blk[n].col  = ocol + OUT_COL_W'(q % 2);
				blk[n].pix  = quad[q];
				blk[n].last = 1'b0;
				n++;
			end
			averaged_results += 4;
		end

		// border pixels are copied straight away
		if (cur_row == 0 || cur_col == 0 || cur_row + 1 >= frame_height
				|| cur_col + 1 >= frame_width) begin
			orow = OUT_ROW_W'(2 * cur_row);
			ocol = OUT_COL_W'(2 * cur_col);
			for (int q = 0; q < 4; q++) begin
				blk[n].row  = orow + OUT_ROW_W'(q / 2);
				blk[n].col  = ocol + OUT_COL_W'(q % 2);
				blk[n].pix  = p;
				blk[n].last = 1'b0;
				n++;
			end
		end

		if (n > 0)
			blk[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			upscaled_queue.push_back(blk[k]);
		head = blk[0];

		// shift the window and line stores, advance the raster position
		older_line[cur_col]  = col_now[1];
		recent_line[cur_col] = p;
		left_col = mid_col;
		mid_col  = col_now;
		cur_col++;
		if (cur_col >= frame_width) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= frame_height)
				cur_row = 0;
		end
		return n;
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t p;
		p = 24'($urandom);
		// now and then push every channel to an extreme
		if ($urandom_range(0, 7) == 0) begin
			for (int k = 0; k < 3; k++)
				p[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return p;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		set_geometry(idx, value);
		settings_used++;
	endtask

	// Offer one pixel, hold it until the transfer, then predict its outputs
	task automatic send_pixel(rgb_t p, output int n, output out_pix_t head);
		@(negedge clk);
		pix_ch.valid = 1'b1;
		pix_ch.red   = p.red;
		pix_ch.green = p.green;
		pix_ch.blue  = p.blue;
		do @(posedge clk); while (!pix_ch.ready);
		n = upscale_pixel(p, head);
		pixels_sent++;
	endtask

	// Now and then drop valid for a random burst
	task automatic source_gap();
		if (!calm && !hold_active && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			pix_ch.valid = 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
		end
	endtask

	// Stop offering, wait for every predicted output, then let the pipeline empty
	task automatic drain_and_settle();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (upscaled_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result sink: random stalls, one long hold-off on request, none at the end
	initial begin
		int stall_left;
		stall_left   = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done    = 1'b1;
				hold_active  = 1'b1;
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_active  = 1'b0;
			end else if (calm) begin
				res_ch.ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready = 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left   = $urandom_range(0, 18);
				res_ch.ready = 1'b0;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// Compare each output transfer with the oldest prediction
	always @(posedge clk) begin : check_outputs
		out_pix_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (upscaled_queue.size() == 0) begin
				$error("output pixel with none predicted: row %0d col %0d",
					res_ch.out_row, res_ch.out_col);
				error_count++;
			end else begin
				want = upscaled_queue.pop_front();
				check_field("out_row", 16'(want.row), 16'(res_ch.out_row));
				check_field("out_col", 16'(want.col), 16'(res_ch.out_col));
				check_field("out_red", 16'(want.pix.red), 16'(res_ch.out_red));
				check_field("out_green", 16'(want.pix.green), 16'(res_ch.out_green));
				check_field("out_blue", 16'(want.pix.blue), 16'(res_ch.out_blue));
				check_field("last", 16'(want.last), 16'(res_ch.last));
				results_checked++;
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("rgb_upscale_2x_quad_average test failed");
				$finish;
			end
		end
	end

	initial begin
		int       n;
		int       count;
		int       target;
		bit       first_phase;
		out_pix_t head;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		table_errors     = 0;
		pixels_sent      = 0;
		averaged_results = 0;
		settings_used    = 0;

		frame_width  = WIDTH_RESET;
		frame_height = HEIGHT_RESET;
		cur_row      = 0;
		cur_col      = 0;
		for (int k = 0; k < LINE_MAX; k++) begin
			older_line[k]  = '0;
			recent_line[k] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			left_col[k] = '0;
			mid_col[k]  = '0;
		end

		// kind, register, value, pixel, typed, first output row, first output col
		directed_rows = '{
			// reset geometry, 640 x 480: first row is border
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFF0080, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h00FF7F, 1'b1, 13'd0, 12'd2},
			// zero geometry acts as 1 x 1: every pixel is a whole frame
			'{STIM_CONFIG, REG_IMAGE_WIDTH,  32'd0,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_CONFIG, REG_IMAGE_HEIGHT, 32'd0,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h000000, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h5AA5C3, 1'b1, 13'd0, 12'd0},
			// oversized geometry clamps to the maximum
			'{STIM_CONFIG, REG_IMAGE_WIDTH,  32'd4095, 24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_CONFIG, REG_IMAGE_HEIGHT, 32'd8191, 24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h123456, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFEDCBA, 1'b1, 13'd0, 12'd2},
			// 3 x 3 frame: one interior pixel, then wrap to the next frame
			'{STIM_CONFIG, REG_IMAGE_WIDTH,  32'd3,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_CONFIG, REG_IMAGE_HEIGHT, 32'd3,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd0, 12'd2},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd0, 12'd4},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd2, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h030102, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd2, 12'd4},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h000000, 1'b1, 13'd4, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFFFF, 1'b1, 13'd4, 12'd2},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h808080, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h0000FF, 1'b1, 13'd0, 12'd0},
			// widest legal line, two rows
			'{STIM_CONFIG, REG_IMAGE_WIDTH,  32'd2048, 24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_CONFIG, REG_IMAGE_HEIGHT, 32'd2,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h00FF00, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h7F807F, 1'b1, 13'd0, 12'd2},
			// tallest legal frame, two columns
			'{STIM_CONFIG, REG_IMAGE_WIDTH,  32'd2,    24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_CONFIG, REG_IMAGE_HEIGHT, 32'd4096, 24'h000000, 1'b0, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hAA5500, 1'b1, 13'd0, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h55AAFF, 1'b1, 13'd0, 12'd2},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'h010203, 1'b1, 13'd2, 12'd0},
			'{STIM_PIXEL,  REG_IMAGE_WIDTH,  32'd0,    24'hFFFEFD, 1'b1, 13'd2, 12'd2}
		};

		// hold reset, then release it between edges
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// walk the directed table; typed rows must be a plain border copy
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == STIM_CONFIG) begin
				drain_and_settle();
				apb_write(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				source_gap();
				send_pixel(directed_rows[i].pix, n, head);
				if (directed_rows[i].typed && (n != 4 || head.row !== directed_rows[i].exp_row
						|| head.col !== directed_rows[i].exp_col
						|| head.pix !== directed_rows[i].pix)) begin
					$error("border block of row %0d: expected (%0d,%0d) x4, predicted (%0d,%0d) x%0d",
						i, directed_rows[i].exp_row, directed_rows[i].exp_col,
						head.row, head.col, n);
					table_errors++;
				end
			end
		end

		// random frames of random geometry, mostly small
		target      = pixels_sent + RANDOM_PIXELS;
		first_phase = 1'b1;
		while (pixels_sent < target) begin
			drain_and_settle();
			if (first_phase) begin
				apb_write(REG_IMAGE_WIDTH, $urandom_range(4, 8));
				apb_write(REG_IMAGE_HEIGHT, 4);
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 7) == 0)
						apb_write(REG_IMAGE_WIDTH, $urandom_range(13, 48));
					else
						apb_write(REG_IMAGE_WIDTH, $urandom_range(1, 12));
				end
				apb_write(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
			end
			count = frame_width * frame_height * $urandom_range(1, 2)
				+ $urandom_range(0, frame_width);
			if (count > PHASE_CAP)
				count = PHASE_CAP;
			if (count > target - pixels_sent)
				count = target - pixels_sent;
			// first phase: hold the result port off so the input backs up
			if (first_phase)
				hold_req = 1'b1;
			repeat (count) begin
				if (target - pixels_sent <= CALM_PIXELS)
					calm = 1'b1;
				source_gap();
				send_pixel(random_pixel(), n, head);
			end
			first_phase = 1'b0;
		end
		drain_and_settle();

		$display("Sent %0d source pixels over %0d register writes; %0d output pixels checked,",
			pixels_sent, settings_used, results_checked);
		$display("%0d of them quadrant averages, the rest border copies.", averaged_results);
		if (error_count == 0 && table_errors == 0)
			$display("rgb_upscale_2x_quad_average test passed");
		else
			$display("rgb_upscale_2x_quad_average test failed");
		$finish;
	end

endmodule

`default_nettype wire
